// ===== rtl/skt_blit_pkg.sv =====
// Package for the scaled, keyed and tinted blit core.
// Holds the register map, the function codes and the pipeline payload types.
// Depends on nothing.
package skt_blit_pkg;

  localparam int unsigned QuotW = 10;
  localparam int unsigned DivStages = 11;

  typedef enum logic [2:0] {
    REG_SRC_ORG_X  = 3'd0,
    REG_SRC_ORG_Y  = 3'd1,
    REG_SRC_SPAN_W = 3'd2,
    REG_SRC_SPAN_H = 3'd3,
    REG_DST_SPAN_W = 3'd4,
    REG_DST_SPAN_H = 3'd5,
    REG_TINT_COLOR = 3'd6,
    REG_KEY_COLOR  = 3'd7
  } reg_idx_e;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_PIXEL = 1'b1
  } func_e;

  typedef struct packed {
    logic [10:0] pix_x;
    logic [10:0] pix_y;
    logic        err;
  } pix_info_t;

  // One restoring division step: 20-bit dividend shifted through a 12-bit remainder.
  typedef struct packed {
    logic [19:0] num;
    logic [11:0] rem;
    logic [10:0] quo;
  } div_state_t;

  function automatic div_state_t div_step(div_state_t s, logic [10:0] den);
    div_state_t r;
    logic [12:0] trial;
    r = s;
    trial = {s.rem, s.num[19]} - {2'b00, den};
    r.num = {s.num[18:0], 1'b0};
    if (!trial[12]) begin
      r.rem = trial[11:0];
      r.quo = {s.quo[9:0], 1'b1};
    end else begin
      r.rem = {s.rem[10:0], s.num[19]};
      r.quo = {s.quo[9:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ===== rtl/scaled_keyed_tinted_blit_core.sv =====
// Scaled, keyed and tinted blit core: top level.
// One request is taken every cycle unless a result at the output is refused.
// The depth is set by the two 20-bit by 11-bit dividers at two bits a stage.
// The whole pipeline advances together and holds while the result is refused.
// Reset clears the valid bits and sets the registers to defaults; data and the texel store are not cleared.
// Depends on skt_blit_pkg and skt_blit_div.
module scaled_keyed_tinted_blit_core
  import skt_blit_pkg::*;
#(
  parameter int unsigned TEX_W = 256,
  parameter int unsigned TEX_H = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic        func_i,
  input  logic [15:0] texel_addr_i,
  input  logic [23:0] texel_value_i,
  input  logic [9:0]  origin_x_i,
  input  logic [9:0]  origin_y_i,
  input  logic [9:0]  off_x_i,
  input  logic [9:0]  off_y_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [10:0] pix_x_o,
  output logic [10:0] pix_y_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic        write_enable_o,
  output logic        range_error_o
);

  localparam int unsigned Depth = 65536;
  localparam int unsigned Lat = 15;
  localparam logic [12:0] TexW = 13'(TEX_W);
  localparam logic [12:0] TexH = 13'(TEX_H);

  logic [7:0]  src_org_x_q, src_org_y_q;
  logic [8:0]  src_span_w_q, src_span_h_q;
  logic [10:0] dst_span_w_q, dst_span_h_q;
  logic [23:0] tint_q, key_q;
  logic        wr_en;
  reg_idx_e    widx;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign widx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_org_x_q <= '0; src_org_y_q <= '0;
      src_span_w_q <= 9'd1; src_span_h_q <= 9'd1;
      dst_span_w_q <= 11'd1; dst_span_h_q <= 11'd1;
      tint_q <= '0; key_q <= '0;
    end else if (wr_en) begin
      case (widx)
        REG_SRC_ORG_X:  src_org_x_q <= pwdata[7:0];
        REG_SRC_ORG_Y:  src_org_y_q <= pwdata[7:0];
        REG_SRC_SPAN_W: src_span_w_q <= pwdata[8:0];
        REG_SRC_SPAN_H: src_span_h_q <= pwdata[8:0];
        REG_DST_SPAN_W: dst_span_w_q <= pwdata[10:0];
        REG_DST_SPAN_H: dst_span_h_q <= pwdata[10:0];
        REG_TINT_COLOR: tint_q <= pwdata[23:0];
        REG_KEY_COLOR:  key_q <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_SRC_ORG_X:  prdata = {24'd0, src_org_x_q};
      REG_SRC_ORG_Y:  prdata = {24'd0, src_org_y_q};
      REG_SRC_SPAN_W: prdata = {23'd0, src_span_w_q};
      REG_SRC_SPAN_H: prdata = {23'd0, src_span_h_q};
      REG_DST_SPAN_W: prdata = {21'd0, dst_span_w_q};
      REG_DST_SPAN_H: prdata = {21'd0, dst_span_h_q};
      REG_TINT_COLOR: prdata = {8'd0, tint_q};
      REG_KEY_COLOR:  prdata = {8'd0, key_q};
      default:        prdata = '0;
    endcase
  end

  // Whole pipeline advances when the output stage is free.
  logic adv;
  logic in_acc;
  assign adv = !valid_o || ready_i;
  assign ready_o = adv;
  assign in_acc = valid_i && ready_o;

  // Texel writes travel down the pipeline so that they reach the store in request order.
  logic        wv_q [12];
  logic [15:0] wa_q [12];
  logic [23:0] wd_q [12];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 12; i++) wv_q[i] <= 1'b0;
    end else if (adv) begin
      wv_q[0] <= in_acc && func_e'(func_i) == FUNC_WRITE;
      for (int i = 1; i < 12; i++) wv_q[i] <= wv_q[i-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      wa_q[0] <= texel_addr_i;
      wd_q[0] <= texel_value_i;
      for (int i = 1; i < 12; i++) begin
        wa_q[i] <= wa_q[i-1];
        wd_q[i] <= wd_q[i-1];
      end
    end
  end

  logic [23:0] store [Depth];
  always_ff @(posedge clk_i) begin
    if (adv && wv_q[11]) store[wa_q[11]] <= wd_q[11];
  end

  // Stage 0: products, output coordinates and offset check.
  logic        v0_q;
  pix_info_t   i0_q;
  logic [19:0] nx_q, ny_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (adv) v0_q <= in_acc && func_e'(func_i) == FUNC_PIXEL;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      i0_q.pix_x <= 11'(origin_x_i) + 11'(off_x_i);
      i0_q.pix_y <= 11'(origin_y_i) + 11'(off_y_i);
      i0_q.err <= ({1'b0, off_x_i} >= dst_span_w_q) || ({1'b0, off_y_i} >= dst_span_h_q);
      nx_q <= 20'(off_x_i) * 20'(src_span_w_q);
      ny_q <= 20'(off_y_i) * 20'(src_span_h_q);
    end
  end

  logic [10:0] qx, qy;
  skt_blit_div u_div_x (.clk_i, .en_i(adv), .num_i(nx_q), .den_i(dst_span_w_q), .quo_o(qx));
  skt_blit_div u_div_y (.clk_i, .en_i(adv), .num_i(ny_q), .den_i(dst_span_h_q), .quo_o(qy));

  logic      vd_q [10];
  pix_info_t id_q [10];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 10; i++) vd_q[i] <= 1'b0;
    end else if (adv) begin
      vd_q[0] <= v0_q;
      for (int i = 1; i < 10; i++) vd_q[i] <= vd_q[i-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      id_q[0] <= i0_q;
      for (int i = 1; i < 10; i++) id_q[i] <= id_q[i-1];
    end
  end

  // Stage A: source coordinate, bounds and store address; stage R: texel read.
  logic [12:0] sx, sy;
  logic [25:0] addr_full;
  logic        a_err;
  assign sx = 13'(src_org_x_q) + 13'(qx);
  assign sy = 13'(src_org_y_q) + 13'(qy);
  assign addr_full = 26'(sx) + 26'(TexH - 13'd1 - sy) * 26'(TexW);
  assign a_err = id_q[9].err || sx >= TexW || sy >= TexH || addr_full >= 26'(Depth);

  logic      va_q, vr_q;
  pix_info_t ia_q, ir_q;
  logic [15:0] aa_q;
  logic [23:0] t_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0; vr_q <= 1'b0;
    end else if (adv) begin
      va_q <= vd_q[9]; vr_q <= va_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ia_q <= '{pix_x: id_q[9].pix_x, pix_y: id_q[9].pix_y, err: a_err};
      aa_q <= addr_full[15:0];
      ir_q <= ia_q;
      t_q <= store[aa_q];
    end
  end

  // Stage M: tint multiply and key compare; stage O: divide by 255 unless the tint is zero, and output.
  logic [15:0] m_q [3];
  logic [23:0] tm_q;
  logic        vm_q, km_q;
  pix_info_t   im_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vm_q <= 1'b0;
    else if (adv) vm_q <= vr_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) m_q[c] <= t_q[8*c +: 8] * tint_q[8*c +: 8];
      tm_q <= t_q;
      km_q <= (t_q == key_q);
      im_q <= ir_q;
    end
  end

  function automatic logic [7:0] div255(logic [15:0] p);
    logic [16:0] s;
    s = 17'(p) + 17'(p[15:8]) + 17'd1;
    return s[15:8];
  endfunction

  logic we;
  assign we = !im_q.err && !km_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else if (adv) valid_o <= vm_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pix_x_o <= im_q.pix_x;
      pix_y_o <= im_q.pix_y;
      write_enable_o <= we;
      range_error_o <= im_q.err;
      if (!we) begin
        red_o <= '0; green_o <= '0; blue_o <= '0;
      end else if (tint_q != '0) begin
        red_o <= div255(m_q[0]); green_o <= div255(m_q[1]); blue_o <= div255(m_q[2]);
      end else begin
        red_o <= tm_q[7:0]; green_o <= tm_q[15:8]; blue_o <= tm_q[23:16];
      end
    end
  end

  logic unused;
  assign unused = ^{Lat[0], QuotW[0], DivStages[0]};

  a_err_no_we: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(write_enable_o && range_error_o)) else $error("error with write");
  a_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !write_enable_o) |-> (red_o == 8'd0 && green_o == 8'd0 && blue_o == 8'd0))
    else $error("colour on skipped pixel");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ready_i) |=> valid_o) else $error("result dropped");

endmodule

// ===== rtl/skt_blit_div.sv =====
// Pipelined restoring divider, two quotient bits a stage, with stall.
// Depends on skt_blit_pkg.
module skt_blit_div
  import skt_blit_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [19:0] num_i,
  input  logic [10:0] den_i,
  output logic [10:0] quo_o
);

  localparam int unsigned NSt = 10;
  div_state_t st_q [NSt];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= div_step(div_step('{num: num_i, rem: '0, quo: '0}, den_i), den_i);
      for (int i = 1; i < NSt; i++) begin
        st_q[i] <= div_step(div_step(st_q[i-1], den_i), den_i);
      end
    end
  end

  assign quo_o = st_q[NSt-1].quo;

endmodule
